>>> src/dmps_pkg.sv
// Shared widths and defaults for the diamond max path sum unit.
`default_nettype none
package dmps_pkg;
  localparam int CELL_W         = 15;
  localparam int SUM_W          = 24;
  localparam int FLOOR_W        = 8;
  localparam int MAX_FLOORS_DEF = 128;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [FLOOR_W-1:0] floor_t;

  function automatic sum_t sat_add(input cell_t v, input sum_t p);
    logic [SUM_W:0] s;
    s = {1'b0, p} + (SUM_W+1)'(v);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic sum_t max2(input sum_t a, input sum_t b);
    return (a > b) ? a : b;
  endfunction
endpackage
`default_nettype wire

>>> src/diamond_max_path_sum_unit.sv
// Top level of the diamond max path sum unit: row store, two-stage update, result queue.
//
// Takes one cell per clock, back to back, in row-major diamond order, and gives the
// best top-to-bottom path sum of each case, through stage 2 and the result queue.
// The rate is set by the row store, a memory with one read and one write port:
// each cell reads one entry in its accept cycle and writes its own entry in the
// next; the other predecessor is carried in a register, and a read that meets
// the write of the cell just before it is forwarded. Results wait in a
// two-entry queue, so input is held off only when that queue could overflow.
// A write of cfg_floor_count abandons any case in progress; write it only when
// the unit is idle. Entries of the row store are read only after written, so
// there is no clearing pass after reset.
`default_nettype none
module diamond_max_path_sum_unit #(
  parameter int MAX_FLOORS = dmps_pkg::MAX_FLOORS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_wr_en,
  input  wire dmps_pkg::floor_t  cfg_floor_count,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire dmps_pkg::cell_t   in_cell_value,
  output logic                   out_valid,
  input  wire                    out_stall,
  output dmps_pkg::sum_t         out_path_max
);
  import dmps_pkg::*;

  localparam int CW = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
  localparam int RW = CW + 1;

  typedef logic [CW-1:0] col_t;
  typedef logic [RW-1:0] row_t;

  // configuration
  row_t n_r, last_row_r;
  row_t n_nxt;

  // stage 1 position
  row_t row_r;
  col_t col_r;
  logic accept;
  logic upper, last_in_row, last_case;
  row_t lim;
  col_t rd_addr;

  // stage 2
  logic s2_valid_r, s2_upper_r, s2_first_row_r, s2_has_left_r, s2_has_up_r;
  logic s2_col0_r, s2_last_row_end_r, s2_last_r;
  col_t s2_col_r;
  cell_t s2_val_r;
  sum_t rd_data_r, fwd_data_r;
  logic fwd_r;
  sum_t mem_q, pred, sum;
  sum_t held_left_r, carry_r, col0_val_r;

  sum_t row_mem [MAX_FLOORS];

  // result queue
  sum_t q_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, occ;
  logic push, pop;

  always_comb begin
    if (cfg_floor_count == '0) begin
      n_nxt = row_t'(1);
    end else if (32'(cfg_floor_count) > 32'(MAX_FLOORS)) begin
      n_nxt = row_t'(MAX_FLOORS);
    end else begin
      n_nxt = row_t'(cfg_floor_count);
    end
  end

  assign accept      = in_valid && !in_stall;
  assign upper       = row_r < n_r;
  assign lim         = upper ? row_r : (last_row_r - row_r);
  assign last_in_row = row_t'(col_r) == lim;
  assign last_case   = last_in_row && (row_r == last_row_r);
  assign rd_addr     = upper ? col_r : col_t'(col_r + col_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r        <= row_t'(1);
      last_row_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
    end else if (cfg_wr_en) begin
      n_r        <= n_nxt;
      last_row_r <= row_t'({n_nxt, 1'b0} - (RW+1)'(2));
      row_r      <= '0;
      col_r      <= '0;
    end else if (accept) begin
      if (last_case) begin
        row_r <= '0;
        col_r <= '0;
      end else if (last_in_row) begin
        row_r <= row_r + row_t'(1);
        col_r <= '0;
      end else begin
        col_r <= col_r + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_upper_r        <= upper;
      s2_first_row_r    <= row_r == '0;
      s2_has_left_r     <= col_r != '0;
      s2_has_up_r       <= row_t'(col_r) < row_r;
      s2_col0_r         <= col_r == '0;
      s2_last_row_end_r <= last_in_row;
      s2_last_r         <= last_case;
      s2_col_r          <= col_r;
      s2_val_r          <= in_cell_value;
      rd_data_r         <= row_mem[rd_addr];
      fwd_r             <= s2_valid_r && (s2_col_r == rd_addr);
      fwd_data_r        <= sum;
    end
  end

  assign mem_q = fwd_r ? fwd_data_r : rd_data_r;

  always_comb begin
    if (s2_upper_r) begin
      if (s2_first_row_r) begin
        pred = '0;
      end else if (s2_has_left_r && s2_has_up_r) begin
        pred = max2(held_left_r, mem_q);
      end else if (s2_has_left_r) begin
        pred = held_left_r;
      end else begin
        pred = mem_q;
      end
    end else begin
      pred = max2(s2_col0_r ? col0_val_r : carry_r, mem_q);
    end
  end

  assign sum = sat_add(s2_val_r, pred);

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      row_mem[s2_col_r] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_left_r <= '0;
      carry_r     <= '0;
    end else if (cfg_wr_en) begin
      held_left_r <= '0;
      carry_r     <= '0;
    end else if (s2_valid_r) begin
      held_left_r <= s2_last_row_end_r ? '0 : mem_q;
      carry_r     <= mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && s2_col0_r) begin
      col0_val_r <= sum;
    end
  end

  // result queue: a transfer out pops, a finished case pushes
  assign push      = s2_valid_r && s2_last_r;
  assign pop       = out_valid && !out_stall;
  assign out_valid = cnt_r != '0;
  assign out_path_max = q_r[rd_ptr_r];
  assign occ       = cnt_r + {1'b0, push} - {1'b0, pop};
  assign in_stall  = occ[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= occ;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= sum;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue overflow");

  a_last_at_col0: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_last_r |-> s2_col0_r)
    else $error("case end not at column zero");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept) && fwd_r |-> $past(s2_valid_r))
    else $error("forward without a write in flight");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !pop |-> !push)
    else $error("push into full result queue");
endmodule
`default_nettype wire

>>> sim/tb_diamond_max_path_sum_unit.sv
// Self-checking testbench for diamond_max_path_sum_unit: directed table, then random diamond cases.
module tb_diamond_max_path_sum_unit;
  import dmps_pkg::*;

  localparam int ROW_SLOTS   = 128;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SCRIPT_LEN  = 23;

  typedef enum logic [0:0] {OP_CFG, OP_CELL} op_e;

  typedef struct packed {
    op_e        op;
    logic [15:0] arg;
    logic       typed;
    sum_t       want;
  } step_t;

  // typed results only where the sum is obvious: one-cell cases and an all-max N=2 case
  localparam step_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{OP_CELL, 16'd0,     1'b1, 24'd0},
    '{OP_CELL, 16'd32767, 1'b1, 24'd32767},
    '{OP_CFG,  16'd0,     1'b0, 24'd0},
    '{OP_CELL, 16'd21845, 1'b1, 24'd21845},
    '{OP_CELL, 16'd10922, 1'b1, 24'd10922},
    '{OP_CFG,  16'd2,     1'b0, 24'd0},
    '{OP_CELL, 16'd32767, 1'b0, 24'd0},
    '{OP_CELL, 16'd32767, 1'b0, 24'd0},
    '{OP_CELL, 16'd32767, 1'b0, 24'd0},
    '{OP_CELL, 16'd32767, 1'b1, 24'd98301},
    '{OP_CFG,  16'd2,     1'b0, 24'd0},
    '{OP_CELL, 16'd5,     1'b0, 24'd0},
    '{OP_CELL, 16'd9,     1'b0, 24'd0},
    '{OP_CFG,  16'd3,     1'b0, 24'd0},
    '{OP_CELL, 16'd1,     1'b0, 24'd0},
    '{OP_CELL, 16'd2,     1'b0, 24'd0},
    '{OP_CELL, 16'd3,     1'b0, 24'd0},
    '{OP_CELL, 16'd4,     1'b0, 24'd0},
    '{OP_CELL, 16'd5,     1'b0, 24'd0},
    '{OP_CELL, 16'd6,     1'b0, 24'd0},
    '{OP_CELL, 16'd7,     1'b0, 24'd0},
    '{OP_CELL, 16'd8,     1'b0, 24'd0},
    '{OP_CELL, 16'd9,     1'b0, 24'd0}
  };

  logic   clk             = 1'b0;
  logic   rst_n           = 1'b0;
  logic   cfg_wr_en       = 1'b0;
  floor_t cfg_floor_count = '0;
  logic   in_valid        = 1'b0;
  logic   in_stall;
  cell_t  in_cell_value   = '0;
  logic   out_valid;
  logic   out_stall       = 1'b0;
  sum_t   out_path_max;

  diamond_max_path_sum_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_floor_count (cfg_floor_count),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_value   (in_cell_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_path_max    (out_path_max)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // diamond predictor state
  sum_t        row_best [ROW_SLOTS];
  int unsigned cur_row     = 0;
  int unsigned cur_col     = 0;
  sum_t        left_carry  = '0;
  floor_t      floor_reg   = 8'd1;

  sum_t path_max_due [$];
  int   err_count   = 0;
  int   cycle_count = 0;
  bit   calm        = 1'b0;
  bit   hold_req    = 1'b0;
  bit   hold_done   = 1'b0;
  int   hold_left   = 0;
  int   burst_left  = 0;

  initial begin
    for (int i = 0; i < ROW_SLOTS; i++) row_best[i] = '0;
  end

  task automatic fold_cell(input cell_t v, output bit done, output sum_t sum);
    int unsigned    n;
    int unsigned    width;
    sum_t           up;
    sum_t           right;
    sum_t           pred;
    logic [SUM_W:0] total;
    n = (floor_reg == 0) ? 1 : ((floor_reg > ROW_SLOTS) ? ROW_SLOTS : floor_reg);
    done = 1'b0;
    sum = '0;
    up = row_best[cur_col];
    if (cur_row < n) begin
      width = cur_row + 1;
      if (cur_row == 0) pred = '0;
      else if (cur_col > 0 && cur_col < cur_row) pred = (left_carry > up) ? left_carry : up;
      else if (cur_col > 0) pred = left_carry;
      else pred = up;
      left_carry = up;
    end else begin
      width = 2 * n - 1 - cur_row;
      right = row_best[cur_col + 1];
      pred = (up > right) ? up : right;
    end
    total = {1'b0, pred} + (SUM_W+1)'(v);
    row_best[cur_col] = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
    cur_col++;
    if (cur_col >= width) begin
      cur_col = 0;
      cur_row++;
      left_carry = '0;
      if (cur_row >= 2 * n - 1) begin
        cur_row = 0;
        done = 1'b1;
        sum = row_best[0];
      end
    end
  endtask

  function automatic cell_t rand_cell();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return {CELL_W{1'b1}};
    return cell_t'($urandom_range(0, 32767));
  endfunction

  task automatic send_cell(input cell_t v, input bit typed, input sum_t typed_sum);
    bit   done;
    sum_t sum;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_value <= v;
    do @(posedge clk); while (in_stall);
    fold_cell(v, done, sum);
    if (done) path_max_due.push_back(typed ? typed_sum : sum);
  endtask

  task automatic write_floor_count(input floor_t v);
    in_valid <= 1'b0;
    while (path_max_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_wr_en       <= 1'b1;
    cfg_floor_count <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    floor_reg  = v;
    cur_row    = 0;
    cur_col    = 0;
    left_carry = '0;
  endtask

  // result side: random stall bursts plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_done = 1'b1;
      hold_left = 59;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      burst_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : watch
    sum_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (path_max_due.size() == 0) begin
        $error("path_max: no transfer expected, got %0d", out_path_max);
        err_count++;
      end else begin
        want = path_max_due.pop_front();
        if (out_path_max !== want) begin
          $error("path_max: expected %0d, got %0d", want, out_path_max);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int          small_cells;
    int          phase;
    int          floors;
    int          side;
    int          cases;
    int          partial;
    int          waited;
    bit          big;
    small_cells = 0;
    phase = 0;
    waited = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].op == OP_CFG) write_floor_count(floor_t'(SCRIPT[i].arg));
      else send_cell(cell_t'(SCRIPT[i].arg), SCRIPT[i].typed, SCRIPT[i].want);
    end

    // phase 0 runs N=2 under a long hold-off so the result queue backs up;
    // phases 1 and 2 load the widest settings and run a case that gets dropped
    while (small_cells < 800) begin
      big = (phase == 1 || phase == 2);
      if (phase == 0) floors = 2;
      else if (phase == 1) floors = 128;
      else if (phase == 2) floors = 255;
      else if ($urandom_range(0, 9) == 0) floors = 0;
      else if ($urandom_range(0, 4) == 0) floors = $urandom_range(11, 16);
      else floors = $urandom_range(1, 10);
      write_floor_count(floor_t'(floors));
      side = (floors == 0) ? 1 : ((floors > ROW_SLOTS) ? ROW_SLOTS : floors);
      if (big) cases = 0;
      else if (phase == 0) cases = 8;
      else if (side > 10) cases = 1;
      else cases = $urandom_range(1, 6);
      if (phase == 0) hold_req = 1'b1;
      for (int k = 0; k < cases * side * side; k++) begin
        send_cell(rand_cell(), 1'b0, '0);
        small_cells++;
      end
      // abandoned case: the next register write drops it
      if (big || (side > 1 && $urandom_range(0, 3) == 0)) begin
        partial = big ? 40 : $urandom_range(1, side * side - 1);
        repeat (partial) begin
          send_cell(rand_cell(), 1'b0, '0);
          small_cells++;
        end
      end
      calm = (small_cells >= 700);
      phase++;
    end

    in_valid <= 1'b0;
    while (path_max_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (path_max_due.size() != 0) begin
      $error("path_max: %0d expected transfers never arrived", path_max_due.size());
      err_count++;
    end
    if (err_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
